### rtl/mlb_pkg.sv
// Shared constants, codes and types of the multi-LED blink controller.
// No dependencies; used by every module of the block by scoped names.
package mlb_pkg;

    localparam int unsigned NUM_LEDS = 4;
    localparam int unsigned TX_LED   = 0;
    localparam int unsigned RX_LED   = 1;

    localparam int unsigned LED_IW    = $clog2(NUM_LEDS);
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned LED_SPACE = 2 ** IDX_W;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned CFG_IW    = 1;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SLOW = 3'd4;

    localparam logic [CFG_IW-1:0] CFG_FAST_PERIOD = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_SLOW_PERIOD = 1'b1;

    localparam logic [TIME_W-1:0] FAST_PERIOD_RESET = 16'd50;
    localparam logic [TIME_W-1:0] SLOW_PERIOD_RESET = 16'd200;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SET  = 4'b0010,
        ST_TICK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic do_set;
        logic do_tick;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic last_led;
    } dp_status_t;

endpackage

### rtl/multi_led_blink_controller_unit.sv
// Top level of the multi-LED blink controller: channel packing and wiring.
// Depends on mlb_pkg, mlb_ctrl and mlb_datapath.
//
// Input stream (s_*): one item per transfer. s_tuser selects the operation:
// 0 sets the mode of one LED, 1 is a millisecond tick carrying now_ms.
// Result stream (m_*): exactly one transfer per input item, carrying the
// active-low level of the shared pin (lit when the TX or RX LED is lit).
// Configuration channel (cfg_*): writes the fast (index 0) and slow
// (index 1) blink periods; always ready, write only while idle.
//
// A set-mode item passes through the states SET and DONE, a tick through
// TICK, which sweeps the LED entries one per cycle through the single
// update unit, and then DONE. DONE loads the output register once it is
// free; a new item is taken only in IDLE, after the last has left DONE.
// The next item is taken while a result still waits on m_tready; its own
// result then holds until the output register frees.
// Reset clears all LED entries, loads periods 50 and 200, empties the output.
module multi_led_blink_controller_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [3:0] led_index, [6:4] mode, [22:7] duration_ms, [38:23] now_ms, [39] zero
    input  logic [mlb_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] operation
    input  logic [mlb_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] pin_level, [7:1] zero
    output logic [mlb_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlb_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [mlb_pkg::TIME_W-1:0]         cfg_data
);

    mlb_pkg::dp_cmd_t    cmd;
    mlb_pkg::dp_status_t status;
    logic                pin_level;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {(mlb_pkg::OUT_DATA_W - 1)'(0), pin_level};

    mlb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_operation (s_tuser[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .status      (status)
    );

    mlb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_led_index   (s_tdata[3:0]),
        .s_mode        (s_tdata[6:4]),
        .s_duration_ms (s_tdata[22:7]),
        .s_now_ms      (s_tdata[38:23]),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pin_level     (pin_level)
    );

endmodule

### rtl/mlb_ctrl.sv
// Sequencer of the blink controller: input acceptance, LED sweep, result handoff.
// Depends on mlb_pkg; drives the datapath through mlb_pkg::dp_cmd_t.
module mlb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_operation,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output mlb_pkg::dp_cmd_t     cmd,
    input  mlb_pkg::dp_status_t  status
);

    mlb_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            accept;
    logic            slot_free;

    assign s_tready  = (state_reg == mlb_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            mlb_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = s_operation ? mlb_pkg::ST_TICK : mlb_pkg::ST_SET;
                end
            end
            mlb_pkg::ST_SET: begin
                cmd.do_set = 1'b1;
                state_next = mlb_pkg::ST_DONE;
            end
            mlb_pkg::ST_TICK: begin
                cmd.do_tick = 1'b1;
                if (status.last_led) begin
                    state_next = mlb_pkg::ST_DONE;
                end
            end
            mlb_pkg::ST_DONE: begin
                if (slot_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = mlb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mlb_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### rtl/mlb_datapath.sv
// LED entry registers, period registers and the per-LED update logic.
// Depends on mlb_pkg; sequenced by mlb_ctrl through command and status structs.
module mlb_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mlb_pkg::dp_cmd_t                    cmd,
    output mlb_pkg::dp_status_t                 status,
    input  logic [mlb_pkg::IDX_W-1:0]           s_led_index,
    input  logic [mlb_pkg::MODE_W-1:0]          s_mode,
    input  logic [mlb_pkg::TIME_W-1:0]          s_duration_ms,
    input  logic [mlb_pkg::TIME_W-1:0]          s_now_ms,
    input  logic                                cfg_write,
    input  logic [mlb_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [mlb_pkg::TIME_W-1:0]          cfg_data,
    output logic                                pin_level
);

    localparam int unsigned N  = mlb_pkg::NUM_LEDS;
    localparam int unsigned IW = mlb_pkg::LED_IW;
    localparam int unsigned TW = mlb_pkg::TIME_W;
    localparam int unsigned MW = mlb_pkg::MODE_W;

    logic [TW-1:0] fast_period_reg, slow_period_reg;

    logic [mlb_pkg::IDX_W-1:0] idx_cap_reg;
    logic [MW-1:0]             mode_cap_reg;
    logic [TW-1:0]             dur_cap_reg;
    logic [TW-1:0]             now_cap_reg;

    logic [MW-1:0] led_mode_reg [N];
    logic [TW-1:0] due_time_reg [N];
    logic [TW-1:0] period_reg   [N];
    logic [TW-1:0] end_time_reg [N];
    logic [N-1:0]  led_lit_reg;

    logic [IW-1:0] cnt_reg;
    logic          pin_reg;

    logic [IW-1:0] sel;
    logic          idx_ok;
    logic [MW-1:0] cur_mode, mode_next;
    logic [TW-1:0] cur_due, due_next;
    logic [TW-1:0] cur_per, per_next;
    logic [TW-1:0] cur_end, end_next;
    logic          cur_lit, lit_next;
    logic          wr;
    logic [TW-1:0] elapsed;
    logic [mlb_pkg::LED_SPACE-1:0] lit_ext;
    logic          pin_next;

    assign sel    = cmd.do_set ? idx_cap_reg[IW-1:0] : cnt_reg;
    assign idx_ok = (32'(idx_cap_reg) < N);

    assign cur_mode = led_mode_reg[sel];
    assign cur_due  = due_time_reg[sel];
    assign cur_per  = period_reg[sel];
    assign cur_end  = end_time_reg[sel];
    assign cur_lit  = led_lit_reg[sel];
    assign elapsed  = now_cap_reg - cur_due;

    assign status.last_led = (cnt_reg == IW'(N - 1));

    always_comb begin
        mode_next = cur_mode;
        due_next  = cur_due;
        per_next  = cur_per;
        end_next  = cur_end;
        lit_next  = cur_lit;
        wr        = 1'b0;
        if (cmd.do_set) begin
            wr        = idx_ok;
            mode_next = mode_cap_reg;
            if (cur_due == '0) begin
                due_next = now_cap_reg | TW'(1);
            end
            per_next = '0;
            end_next = dur_cap_reg;
            if (mode_cap_reg == mlb_pkg::MODE_FAST || mode_cap_reg == mlb_pkg::MODE_SLOW) begin
                per_next = (mode_cap_reg == mlb_pkg::MODE_FAST) ? fast_period_reg
                                                                : slow_period_reg;
                end_next = (dur_cap_reg != '0) ? ((now_cap_reg + dur_cap_reg) | TW'(1))
                                               : '0;
            end
        end else if (cmd.do_tick) begin
            if (cur_due != '0 && elapsed >= cur_per) begin
                wr = 1'b1;
                case (cur_mode)
                    mlb_pkg::MODE_OFF, mlb_pkg::MODE_ON: begin
                        lit_next = (cur_mode == mlb_pkg::MODE_ON);
                        due_next = '0;
                    end
                    mlb_pkg::MODE_FAST, mlb_pkg::MODE_SLOW: begin
                        lit_next = !cur_lit;
                        due_next = (cur_due + cur_per) | TW'(1);
                        if (cur_end != '0 && cur_end <= now_cap_reg) begin
                            mode_next = mlb_pkg::MODE_OFF;
                            per_next  = '0;
                            end_next  = '0;
                        end
                    end
                    default: begin
                        due_next = '0;
                    end
                endcase
            end
        end
    end

    assign lit_ext  = mlb_pkg::LED_SPACE'(led_lit_reg);
    assign pin_next = !(lit_ext[mlb_pkg::TX_LED] || lit_ext[mlb_pkg::RX_LED]);
    assign pin_level = pin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_period_reg <= mlb_pkg::FAST_PERIOD_RESET;
            slow_period_reg <= mlb_pkg::SLOW_PERIOD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                mlb_pkg::CFG_FAST_PERIOD: fast_period_reg <= cfg_data;
                mlb_pkg::CFG_SLOW_PERIOD: slow_period_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_cap_reg  <= s_led_index;
            mode_cap_reg <= s_mode;
            dur_cap_reg  <= s_duration_ms;
            now_cap_reg  <= s_now_ms;
        end
        if (cmd.load_out) begin
            pin_reg <= pin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.do_tick) begin
            cnt_reg <= cnt_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                led_mode_reg[i] <= '0;
                due_time_reg[i] <= '0;
                period_reg[i]   <= '0;
                end_time_reg[i] <= '0;
            end
            led_lit_reg <= '0;
        end else if (wr) begin
            led_mode_reg[sel] <= mode_next;
            due_time_reg[sel] <= due_next;
            period_reg[sel]   <= per_next;
            end_time_reg[sel] <= end_next;
            led_lit_reg[sel]  <= lit_next;
        end
    end

endmodule

### rtl/mlb_checker.sv
// Port-level checks of the blink controller, attached by bind.
// Depends on mlb_pkg and the ports of multi_led_blink_controller_unit.
module mlb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mlb_pkg::OUT_DATA_W-1:0]  m_tdata
);

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after input transfer");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind multi_led_blink_controller_unit mlb_checker u_mlb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/multi_led_blink_controller_unit_test.sv
// Self-checking bench for multi_led_blink_controller_unit: directed and random set-mode
// and tick streams under random stalls on both sides, checked against an in-bench model
// of the LED table. Depends on mlb_pkg and the RTL of the block.
module multi_led_blink_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mlb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic              OP_SET    = 1'b0;
    localparam logic              OP_TICK   = 1'b1;
    localparam int unsigned       CYCLE_LIMIT = 400000;
    localparam int unsigned       DRAIN_LIMIT = 60000;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] now;
    } blink_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IW-1:0]     cfg_index = '0;
    logic [TIME_W-1:0]     cfg_data  = '0;

    multi_led_blink_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // LED table model
    logic [MODE_W-1:0] led_mode_m  [NUM_LEDS];
    logic [TIME_W-1:0] due_m       [NUM_LEDS];
    logic [TIME_W-1:0] period_m    [NUM_LEDS];
    logic [TIME_W-1:0] stop_m      [NUM_LEDS];
    logic              lit_m       [NUM_LEDS];
    logic [TIME_W-1:0] fast_period_m;
    logic [TIME_W-1:0] slow_period_m;

    blink_item_t pending_items[$];
    logic        expected_pin_levels[$];
    blink_item_t tx_item;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    logic        tx_live;
    logic        want_pin;
    logic        calm = 1'b0;
    logic [TIME_W-1:0] ms_clock = 16'd300;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_ticks = 0;
    int unsigned n_sets = 0;
    int unsigned n_results = 0;
    int unsigned n_settings = 1;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    function automatic void clear_led_table();
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_mode_m[i] = MODE_NONE;
            due_m[i]      = '0;
            period_m[i]   = '0;
            stop_m[i]     = '0;
            lit_m[i]      = 1'b0;
        end
        fast_period_m = FAST_PERIOD_RESET;
        slow_period_m = SLOW_PERIOD_RESET;
    endfunction

    function automatic void apply_mode(int unsigned idx, logic [MODE_W-1:0] m,
                                       logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] stop;
        logic [TIME_W-1:0] sum;
        stop = dur;
        sum  = now + dur;
        if (idx >= NUM_LEDS)
            return;
        led_mode_m[idx] = m;
        if (due_m[idx] == '0)
            due_m[idx] = now | 16'd1;
        period_m[idx] = '0;
        if (m == MODE_FAST || m == MODE_SLOW) begin
            period_m[idx] = (m == MODE_FAST) ? fast_period_m : slow_period_m;
            stop = (dur != '0) ? (sum | 16'd1) : '0;
        end
        stop_m[idx] = stop;
    endfunction

    function automatic logic lit_of(int unsigned idx);
        if (idx >= NUM_LEDS)
            return 1'b0;
        return lit_m[idx];
    endfunction

    function automatic logic predict_pin_level(blink_item_t it);
        logic [TIME_W-1:0] elapsed;
        if (it.op == OP_SET) begin
            apply_mode(it.idx, it.mode, it.dur, it.now);
        end else begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (due_m[i] == '0)
                    continue;
                elapsed = it.now - due_m[i];
                if (elapsed < period_m[i])
                    continue;
                case (led_mode_m[i])
                    MODE_OFF, MODE_ON: begin
                        lit_m[i] = (led_mode_m[i] == MODE_ON);
                        due_m[i] = '0;
                    end
                    MODE_FAST, MODE_SLOW: begin
                        lit_m[i] = ~lit_m[i];
                        due_m[i] = (due_m[i] + period_m[i]) | 16'd1;
                        if (stop_m[i] != '0 && stop_m[i] <= it.now)
                            apply_mode(i, MODE_OFF, '0, it.now);
                    end
                    default: begin
                        due_m[i] = '0;
                    end
                endcase
            end
        end
        return (lit_of(TX_LED) | lit_of(RX_LED)) ? 1'b0 : 1'b1;
    endfunction

    function automatic int unsigned draw_wait();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap = 0;
        end else begin
            tx_live = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_pin_levels.push_back(predict_pin_level(tx_item));
                n_accepted++;
                if (tx_item.op == OP_TICK)
                    n_ticks++;
                else
                    n_sets++;
                tx_gap = draw_wait();
                tx_live = 1'b0;
            end
            if (!tx_live) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() > 0) begin
                    tx_item = pending_items.pop_front();
                    s_tdata <= {1'b0, tx_item.now, tx_item.dur, tx_item.mode, tx_item.idx};
                    s_tuser <= tx_item.op;
                    tx_live = 1'b1;
                end
            end
            s_tvalid <= tx_live;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_pin_levels.size() == 0) begin
                    $error("pin_level: unexpected transfer, expected none, actual %0b",
                           m_tdata[0]);
                    errors++;
                end else begin
                    want_pin = expected_pin_levels.pop_front();
                    if (m_tdata[0] !== want_pin) begin
                        $error("pin_level: expected %0b, actual %0b", want_pin, m_tdata[0]);
                        errors++;
                    end
                end
                if (m_tdata[OUT_DATA_W-1:1] !== '0) begin
                    $error("pad: expected 0, actual %0h", m_tdata[OUT_DATA_W-1:1]);
                    errors++;
                end
                rx_stall = draw_wait();
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_item(logic op, logic [IDX_W-1:0] idx, logic [MODE_W-1:0] mode,
                              logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now);
        blink_item_t it;
        it.op   = op;
        it.idx  = idx;
        it.mode = mode;
        it.dur  = dur;
        it.now  = now;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic queue_random_item();
        blink_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it.idx  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, NUM_LEDS - 1));
        it.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0: it.dur = '0;
            1: it.dur = 16'($urandom_range(1, 40));
            2: it.dur = 16'($urandom_range(1, 400));
            default: it.dur = 16'($urandom);
        endcase
        it.now = ms_clock;
        if (pick < 68) begin
            it.op = OP_TICK;
            case ($urandom_range(0, 29))
                0: ms_clock = 16'($urandom);
                1, 2, 3: ms_clock = ms_clock + 16'($urandom_range(2, 400));
                default: ms_clock = ms_clock + 16'd1;
            endcase
        end else if (pick < 94) begin
            it.op = OP_SET;
        end else begin
            it.op  = 1'($urandom);
            it.now = 16'($urandom);
        end
        queue_item(it.op, it.idx, it.mode, it.dur, it.now);
    endtask

    task automatic wait_drain();
        int unsigned spins;
        spins = 0;
        while ((n_accepted != n_queued || expected_pin_levels.size() != 0)
               && spins < DRAIN_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        if (n_accepted != n_queued || expected_pin_levels.size() != 0) begin
            $error("pin_level: expected %0d more transfers, actual none",
                   expected_pin_levels.size() + n_queued - n_accepted);
            errors++;
        end
        repeat (NUM_LEDS + 4) @(posedge aclk);
    endtask

    task automatic write_period(logic [CFG_IW-1:0] idx, logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_FAST_PERIOD)
            fast_period_m = value;
        else
            slow_period_m = value;
    endtask

    task automatic run_phase(logic [TIME_W-1:0] fast, logic [TIME_W-1:0] slow,
                             int unsigned count, logic quiet);
        write_period(CFG_FAST_PERIOD, fast);
        write_period(CFG_SLOW_PERIOD, slow);
        cfg_valid <= 1'b0;
        n_settings++;
        calm = quiet;
        for (int unsigned k = 0; k < count; k++)
            queue_random_item();
        wait_drain();
    endtask

    initial begin
        clear_led_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd0);
        queue_item(OP_SET,  4'd0,  MODE_ON,   16'd0,     16'd10);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd11);
        queue_item(OP_SET,  4'd1,  MODE_FAST, 16'd0,     16'd20);
        queue_item(OP_TICK, 4'd15, 3'd7,      16'hFFFF,  16'd21);
        queue_item(OP_SET,  4'd0,  MODE_OFF,  16'd0,     16'd30);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd31);
        queue_item(OP_SET,  4'd4,  MODE_ON,   16'd0,     16'd32);
        queue_item(OP_SET,  4'd15, 3'd7,      16'hFFFF,  16'hFFFF);
        queue_item(OP_SET,  4'd2,  3'd5,      16'd7,     16'd40);
        queue_item(OP_SET,  4'd3,  3'd7,      16'd0,     16'd40);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd41);
        queue_item(OP_SET,  4'd1,  MODE_SLOW, 16'hFFFF,  16'hFFFF);
        queue_item(OP_SET,  4'd0,  MODE_FAST, 16'd3,     16'd100);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd100);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd101);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd151);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd152);
        queue_item(OP_SET,  4'd1,  MODE_NONE, 16'd0,     16'd200);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd200);
        queue_item(OP_SET,  4'd0,  MODE_SLOW, 16'd1,     16'hFFFF);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'hFFFF);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd0);
        queue_item(OP_TICK, 4'd0,  MODE_NONE, 16'd0,     16'd260);
        for (int unsigned k = 0; k < 230; k++)
            queue_random_item();
        wait_drain();

        run_phase(16'd1,     16'd2,     250, 1'b0);
        run_phase(16'hFFFF,  16'hFFFF,  200, 1'b0);
        run_phase(16'd0,     16'd0,     120, 1'b0);
        run_phase(16'd3,     16'd1,     250, 1'b1);
        run_phase(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)), 250, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 20)), 200, 1'b0);
        run_phase(FAST_PERIOD_RESET, SLOW_PERIOD_RESET, 250, 1'b0);

        repeat (20) @(posedge aclk);
        $display("Ran %0d ticks and %0d set-mode items across %0d period settings,",
                 n_ticks, n_sets, n_settings);
        $display("with random stalls on both streams; %0d pin levels checked.", n_results);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
